// ===== hw/rtl/dmse_pkg.sv =====
// Shared constants and action codes for the road-length table engine.
package dmse_pkg;
  localparam int MAX_CITIES_DEF  = 64;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int CITY_W          = 7;
  localparam int LEN_OUT_W       = 17;
  localparam int MAX_RESULTS     = 64;

  localparam logic [2:0] ACT_WRITE = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_RELAY = 3'd2;
  localparam logic [2:0] ACT_MOST  = 3'd3;
  localparam logic [2:0] ACT_NEIGH = 3'd4;

  localparam logic [0:0] REG_CITY_COUNT = 1'd0;
endpackage

// ===== hw/rtl/dmse_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module dmse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/distance_matrix_stopover_engine.sv =====
// Top level: road-length table in one RAM, sequencer for all actions.
// Each named action ends in a result word in the output register; a rejected city is answered
// from idle without a table access, and result stalls delay the answer.
// One word in flight at a time; a write holds the input while it writes the mirror
// entry, and the single RAM port (one table entry per cycle while results are not stalled) sets the rate.
// Synchronous active-low reset clears city_count and control, then every RAM entry is cleared to zero.
module distance_matrix_stopover_engine
  import dmse_pkg::*;
#(
  parameter int MAX_CITIES  = MAX_CITIES_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [0:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_action,
  input  logic [CITY_W-1:0]    in_first_city,
  input  logic [CITY_W-1:0]    in_second_city,
  input  logic [15:0]          in_road_length,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CITY_W-1:0]    out_city_out,
  output logic [LEN_OUT_W-1:0] out_length_out,
  output logic [CITY_W-1:0]    out_degree_out,
  output logic                 out_found,
  output logic                 out_last
);
  localparam int IW = $clog2(MAX_CITIES);
  localparam int AW = 2 * IW;
  localparam int CW = IW + 1;
  localparam int SW = LENGTH_BITS + 1;

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_WR2 = 4'd2, S_RDW = 4'd3,
    S_RLA = 4'd4, S_RLB = 4'd5, S_RLC = 4'd6, S_MC = 4'd7, S_NB = 4'd8,
    S_OUT = 4'd9, S_NBO = 4'd10;

  logic [3:0] st_r;
  logic [CITY_W-1:0] cnt_r;
  logic [AW-1:0] clr_r;
  logic [IW-1:0] i_r, j_r, c_r, r_r;
  logic [CW-1:0] deg_r, bdeg_r;
  logic [IW-1:0] best_r;
  logic bfound_r, dirty_r;
  logic [LENGTH_BITS-1:0] d1_r, wv_r;
  logic [SW-1:0] bsum_r;
  logic [CW-1:0] k_r;

  logic we;
  logic [AW-1:0] addr;
  logic [LENGTH_BITS-1:0] wdata, rdata;

  dmse_ram #(.WIDTH(LENGTH_BITS), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  // Effective city count clamps at MAX_CITIES
  logic [CW-1:0] n;
  assign n = (32'(cnt_r) > MAX_CITIES) ? CW'(MAX_CITIES) : CW'(cnt_r);
  logic a_ok, b_ok;
  assign a_ok = (in_first_city != '0) && (32'(in_first_city) <= 32'(n));
  assign b_ok = (in_second_city != '0) && (32'(in_second_city) <= 32'(n));
  logic [IW-1:0] ai, bi;
  assign ai = IW'(in_first_city - 1'b1);
  assign bi = IW'(in_second_city - 1'b1);

  // Output register
  logic ov_r;
  logic [CITY_W-1:0] oc_r, od_r;
  logic [LEN_OUT_W-1:0] ol_r;
  logic of_r, olst_r;
  assign out_valid = ov_r;
  assign out_city_out = oc_r;
  assign out_length_out = ol_r;
  assign out_degree_out = od_r;
  assign out_found = of_r;
  assign out_last = olst_r;
  logic oslot;
  assign oslot = !ov_r || !out_stall;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_CITY_COUNT) ? 32'(cnt_r) : 32'd0;
  assign in_stall = (st_r != S_IDLE) || !oslot;
  logic acc;
  assign acc = in_valid && !in_stall;

  logic last_c, last_r;
  assign last_c = (CW'(c_r) + 1'b1) == n;
  assign last_r = (CW'(r_r) + 1'b1) == n;
  logic [SW-1:0] sum;
  assign sum = SW'(d1_r) + SW'(rdata);

  // Neighbour walk holds its read while a found word waits for the output slot
  logic nb_hit, nb_hold;
  assign nb_hit = rdata != '0;
  assign nb_hold = nb_hit && dirty_r && !oslot;

  // Load a result word into the output register
  logic ld;
  always_comb begin
    ld = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (acc) begin
          case (in_action)
            ACT_WRITE: ld = 1'b1;
            ACT_READ, ACT_RELAY: ld = !(a_ok && b_ok);
            ACT_MOST: ld = (n == '0);
            ACT_NEIGH: ld = !a_ok;
            default: ld = 1'b0;
          endcase
        end
      end
      S_RDW: ld = 1'b1;
      S_NB: ld = nb_hit && dirty_r && oslot;
      S_RLC, S_OUT, S_NBO: ld = oslot;
      default: ld = 1'b0;
    endcase
  end

  // Address and write data selection
  always_comb begin
    we = 1'b0; addr = '0; wdata = wv_r;
    case (st_r)
      S_CLR: begin we = 1'b1; addr = clr_r; wdata = '0; end
      S_IDLE: begin
        addr = {ai, bi};
        if (acc && in_action == ACT_WRITE && a_ok && b_ok) begin
          we = 1'b1; wdata = LENGTH_BITS'(in_road_length);
        end else if (in_action == ACT_RELAY || in_action == ACT_NEIGH) begin
          addr = {ai, IW'(0)};
        end else if (in_action == ACT_MOST) begin
          addr = '0;
        end
      end
      S_WR2: begin we = 1'b1; addr = {j_r, i_r}; end
      S_RLA: addr = {c_r, j_r};
      S_RLB: addr = {i_r, c_r + 1'b1};
      S_MC: addr = last_c ? {r_r + 1'b1, IW'(0)} : {r_r, c_r + 1'b1};
      S_NB: addr = nb_hold ? {i_r, c_r} : {i_r, c_r + 1'b1};
      default: addr = '0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_CITY_COUNT)
        cnt_r <= cfg_pwdata[CITY_W-1:0];
      if (ld) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) st_r <= S_IDLE;
        end
        S_IDLE: if (acc) begin
          i_r <= ai; j_r <= bi; c_r <= '0; r_r <= '0;
          wv_r <= LENGTH_BITS'(in_road_length);
          bfound_r <= 1'b0; deg_r <= '0; bdeg_r <= '0; best_r <= '0;
          k_r <= '0; dirty_r <= 1'b0;
          case (in_action)
            ACT_WRITE: begin
              if (a_ok && b_ok) st_r <= S_WR2;
              oc_r <= '0; ol_r <= '0; od_r <= '0;
              of_r <= a_ok && b_ok; olst_r <= 1'b1;
            end
            ACT_READ: begin
              if (a_ok && b_ok) st_r <= S_RDW;
              else begin
                oc_r <= '0; ol_r <= '0; od_r <= '0;
                of_r <= 1'b0; olst_r <= 1'b1;
              end
            end
            ACT_RELAY: begin
              if (a_ok && b_ok) st_r <= S_RLA;
              else begin
                oc_r <= '0; ol_r <= '0; od_r <= '0;
                of_r <= 1'b0; olst_r <= 1'b1;
              end
            end
            ACT_MOST: begin
              if (n != '0) st_r <= S_MC;
              else begin
                oc_r <= '0; ol_r <= '0; od_r <= '0;
                of_r <= 1'b0; olst_r <= 1'b1;
              end
            end
            ACT_NEIGH: begin
              if (a_ok) st_r <= S_NB;
              else begin
                oc_r <= '0; ol_r <= '0; od_r <= '0;
                of_r <= 1'b0; olst_r <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_WR2: st_r <= S_IDLE;
        S_RDW: begin
          oc_r <= '0; ol_r <= LEN_OUT_W'(rdata); od_r <= '0;
          of_r <= rdata != '0; olst_r <= 1'b1; st_r <= S_IDLE;
        end
        // Relay: first leg read, then second leg
        S_RLA: begin d1_r <= rdata; st_r <= S_RLB; end
        S_RLB: begin
          if (c_r != i_r && d1_r != '0 && rdata != '0 &&
              (!bfound_r || sum < bsum_r)) begin
            bfound_r <= 1'b1; bsum_r <= sum; best_r <= c_r;
          end
          if (last_c) st_r <= S_RLC;
          else begin c_r <= c_r + 1'b1; st_r <= S_RLA; end
        end
        S_RLC: if (oslot) begin
          oc_r <= bfound_r ? CITY_W'(best_r) + 1'b1 : '0;
          ol_r <= bfound_r ? LEN_OUT_W'(bsum_r) : '0; od_r <= '0;
          of_r <= bfound_r; olst_r <= 1'b1; st_r <= S_IDLE;
        end
        // Degree scan, one entry per cycle
        S_MC: begin
          if (last_c) begin
            if (r_r == '0 || (deg_r + CW'(rdata != '0)) > bdeg_r) begin
              bdeg_r <= deg_r + CW'(rdata != '0); best_r <= r_r;
            end
            deg_r <= '0; c_r <= '0;
            if (last_r) st_r <= S_OUT;
            else r_r <= r_r + 1'b1;
          end else begin
            deg_r <= deg_r + CW'(rdata != '0); c_r <= c_r + 1'b1;
          end
        end
        S_OUT: if (oslot) begin
          oc_r <= CITY_W'(best_r) + 1'b1; ol_r <= '0;
          od_r <= CITY_W'(bdeg_r); of_r <= 1'b1; olst_r <= 1'b1; st_r <= S_IDLE;
        end
        // Neighbour walk: hold one pending word, send it when the next one shows up
        S_NB: if (!nb_hold) begin
          if (nb_hit) begin
            if (dirty_r) begin
              oc_r <= CITY_W'(best_r) + 1'b1; ol_r <= LEN_OUT_W'(d1_r); od_r <= '0;
              of_r <= 1'b1; olst_r <= 1'b0;
            end
            d1_r <= rdata; best_r <= c_r; dirty_r <= 1'b1; k_r <= k_r + 1'b1;
          end
          if (last_c || (nb_hit && k_r + 1'b1 == CW'(MAX_RESULTS))) st_r <= S_NBO;
          else c_r <= c_r + 1'b1;
        end
        // Flush the pending word with last set, or answer not found
        S_NBO: if (oslot) begin
          od_r <= '0; of_r <= dirty_r; olst_r <= 1'b1;
          oc_r <= dirty_r ? CITY_W'(best_r) + 1'b1 : '0;
          ol_r <= dirty_r ? LEN_OUT_W'(d1_r) : '0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/dmse_checker.sv =====
// Port-level checker for the road-length engine, bound to the top level.
module dmse_port_assert
  import dmse_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_found,
  input logic [CITY_W-1:0] out_city_out,
  input logic cfg_pready
);
  // Stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("out word dropped");
  // A stalled result word blocks the input
  a_blk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall) else $error("input open while output blocked");
  // Register port is always ready
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");
  // A word without found never names a city
  a_nf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_city_out == '0) else $error("city without found");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind distance_matrix_stopover_engine dmse_port_assert u_dmse_port_assert (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
  .out_city_out(out_city_out), .cfg_pready(cfg_pready));
